// ===== rtl/safr_pkg.sv =====
`default_nettype none

package safr_pkg;

    // Geometry of the tag store.
    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int TAG_BITS = 26;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 32;

    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int ENTRY_W = TAG_BITS + STAMP_W;   // {stamp, tag}
    localparam int ROW_W   = WAYS * ENTRY_W;

    // Register port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_REPLACE_POLICY = REG_IDX_W'(0);

    localparam logic REPLACE_POLICY_RESET = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // latch set/tag and read the set row
        logic commit;    // write back the row, update counters, load result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;  // result register full and not drained this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/safr_in_if.sv =====
`default_nettype none

interface safr_in_if import safr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SET_W-1:0]    set_index;
    logic [TAG_BITS-1:0] fill_tag;

    modport source (output valid, output set_index, output fill_tag, input ready);
    modport sink   (input valid, input set_index, input fill_tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/safr_out_if.sv =====
`default_nettype none

interface safr_out_if import safr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WAY_W-1:0]    way_used;
    logic                replaced;
    logic [TAG_BITS-1:0] evicted_tag;
    logic [CNT_W-1:0]    replacement_count;

    modport source (
        output valid, output way_used, output replaced, output evicted_tag,
        output replacement_count, input ready
    );
    modport sink (
        input valid, input way_used, input replaced, input evicted_tag,
        input replacement_count, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/safr_ctrl.sv =====
`default_nettype none

module safr_ctrl import safr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    always_comb begin
        o_cmd.capture = r_in_ready && i_in_valid;
        o_cmd.commit  = (r_state == S_LOOK) && !i_status.out_busy;
        n_state       = r_state;
        n_in_ready    = r_in_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state    = S_LOOK;
                    n_in_ready = 1'b0;
                end
            end
            S_LOOK: begin
                // hold until the result register can take the new result
                if (o_cmd.commit) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready == (r_state == S_IDLE))
        else $error("safr_ctrl: ready out of step with state");

endmodule

`default_nettype wire

// ===== rtl/safr_dpath.sv =====
`default_nettype none

module safr_dpath import safr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [SET_W-1:0]    i_set_index,
    input  logic [TAG_BITS-1:0] i_fill_tag,
    safr_out_if.source          o_out
);

    // One row per set: WAYS entries of {stamp, tag}.
    logic [ROW_W-1:0]    r_mem [SETS];
    logic [ROW_W-1:0]    r_rd_row;
    logic [SET_W-1:0]    r_set;
    logic [TAG_BITS-1:0] r_tag;

    logic [WAYS-1:0]     r_valid [SETS];
    logic [CNT_W-1:0]    r_stamp_cnt;
    logic [CNT_W-1:0]    r_evict_total;

    logic                r_out_valid;
    logic [WAY_W-1:0]    r_out_way;
    logic                r_out_replaced;
    logic [TAG_BITS-1:0] r_out_evicted_tag;
    logic [CNT_W-1:0]    r_out_count;

    logic [WAYS-1:0]     vld;
    logic                found;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim;
    logic [STAMP_W-1:0]  least;
    logic [STAMP_W-1:0]  stamp;
    logic [WAY_W-1:0]    way;
    logic [CNT_W-1:0]    n_stamp_cnt;
    logic [CNT_W-1:0]    n_evict_total;
    logic [TAG_BITS-1:0] evicted;
    logic [ROW_W-1:0]    wr_row;

    always_comb begin
        vld = r_valid[r_set];

        // lowest-numbered free way
        found    = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!vld[w]) begin
                found    = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        // oldest stamp; ties go to the lower way
        least  = '1;
        victim = '0;
        for (int w = 0; w < WAYS; w++) begin
            stamp = r_rd_row[w*ENTRY_W + TAG_BITS +: STAMP_W];
            if (stamp < least) begin
                least  = stamp;
                victim = WAY_W'(w);
            end
        end

        way           = found ? free_way : victim;
        n_stamp_cnt   = r_stamp_cnt + CNT_W'(1);
        n_evict_total = r_evict_total + CNT_W'(!found);
        evicted       = found ? '0 : r_rd_row[victim*ENTRY_W +: TAG_BITS];

        wr_row = r_rd_row;
        wr_row[way*ENTRY_W +: ENTRY_W] = {n_stamp_cnt, r_tag};
    end

    // Tag/stamp memory: registered read on capture, row write on commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_row <= r_mem[i_set_index];
            r_set    <= i_set_index;
            r_tag    <= i_fill_tag;
        end
        if (i_cmd.commit) begin
            r_mem[r_set] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_way         <= way;
            r_out_replaced    <= !found;
            r_out_evicted_tag <= evicted;
            r_out_count       <= n_evict_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_stamp_cnt   <= '0;
            r_evict_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid[r_set][way] <= 1'b1;
                r_stamp_cnt         <= n_stamp_cnt;
                r_evict_total       <= n_evict_total;
                r_out_valid         <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !o_out.ready;

    assign o_out.valid             = r_out_valid;
    assign o_out.way_used          = r_out_way;
    assign o_out.replaced          = r_out_replaced;
    assign o_out.evicted_tag       = r_out_evicted_tag;
    assign o_out.replacement_count = r_out_count;

    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_stamp_cnt == $past(r_stamp_cnt) + CNT_W'(1))
        else $error("safr_dpath: stamp counter did not advance by one");

    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_evict_total == $past(r_evict_total) + CNT_W'(r_out_replaced))
        else $error("safr_dpath: eviction total out of step with result");

    a_free_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_replaced) |-> r_out_evicted_tag == '0)
        else $error("safr_dpath: evicted tag set on a free-way fill");

    a_way_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[$past(r_set)][$past(way)])
        else $error("safr_dpath: filled way not marked valid");

endmodule

`default_nettype wire

// ===== rtl/set_assoc_fill_replace.sv =====
// Miss-fill engine for a 64-set, 4-way tag store. Each input transaction names
// a set and a tag; the tag goes into the lowest-numbered invalid way of that set,
// or, when all ways are valid, replaces the way with the smallest insertion stamp
// (lowest way on a tie), and the running eviction total rises by one. Every fill
// takes the next value of a free-running 32-bit stamp counter. Each input gives
// exactly one output transaction: way used, replaced flag, evicted tag (zero on a
// free-way fill) and the eviction total after the fill. A fill has two steps:
// first read the set's row of tags and stamps from the single-port memory
// (registered read), then choose the way and write the row back, so the block
// takes no new input until the write-back; it also holds off input while a
// finished result waits in the output register and the next one is done. Valid
// bits sit in flip-flops cleared by reset, so no clearing pass is needed and the
// block takes input from the first cycle after reset. The replace_policy
// register (address 0) is kept and read back; both settings evict the oldest
// stamp, so it does not change any result.

`default_nettype none

module set_assoc_fill_replace import safr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    safr_in_if.sink               i_in,
    safr_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    logic                 r_replace_policy;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    // Register port: always ready, written on the access phase.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_policy <= REPLACE_POLICY_RESET;
        end else if (cfg_wr && (reg_idx == REG_REPLACE_POLICY)) begin
            r_replace_policy <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_REPLACE_POLICY) begin
            prdata = {{(APB_DATA_W-1){1'b0}}, r_replace_policy};
        end
    end

    // Sequencer: accept, look up, commit.
    safr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Tag/stamp memory, valid bits, counters and the result register.
    safr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_set_index (i_in.set_index),
        .i_fill_tag  (i_in.fill_tag),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/fill_checker.sv =====
`timescale 1ns / 100ps

// Watches the fill and result channels, predicts each fill's outcome from
// its own copy of the tag store, and compares results in order.
module fill_checker import safr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    safr_in_if                    i_fill,
    safr_out_if                   i_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [WAY_W-1:0]    way;
        logic                replaced;
        logic [TAG_BITS-1:0] evicted;
        logic [CNT_W-1:0]    total;
    } t_fill_outcome;

    logic [TAG_BITS-1:0] line_tag   [SETS][WAYS];
    logic                line_valid [SETS][WAYS];
    logic [STAMP_W-1:0]  line_stamp [SETS][WAYS];
    logic [STAMP_W-1:0]  stamp_now;
    logic [CNT_W-1:0]    evictions;
    logic                policy_mirror;
    t_fill_outcome       awaited [$];
    int                  tally;

    task automatic note_mismatch(input string msg);
        tally++;
        if (tally <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Free way first (lowest index); otherwise the smallest stamp, lowest way on a tie.
    task automatic place_fill(input logic [SET_W-1:0] s, input logic [TAG_BITS-1:0] t,
                              output t_fill_outcome r);
        int                 victim;
        logic               found;
        logic [STAMP_W-1:0] least;
        victim = 0;
        found  = 1'b0;
        r      = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!line_valid[s][w]) begin
                victim = w;
                found  = 1'b1;
            end
        end
        if (!found) begin
            evictions = evictions + CNT_W'(1);
            least     = '1;
            victim    = 0;
            for (int w = 0; w < WAYS; w++) begin
                if (line_stamp[s][w] < least) begin
                    least  = line_stamp[s][w];
                    victim = w;
                end
            end
            r.replaced = 1'b1;
            r.evicted  = line_tag[s][victim];
        end
        stamp_now                = stamp_now + STAMP_W'(1);
        line_tag[s][victim]      = t;
        line_valid[s][victim]    = 1'b1;
        line_stamp[s][victim]    = stamp_now;
        r.way                    = victim[WAY_W-1:0];
        r.total                  = evictions;
    endtask

    task automatic check_result(input t_fill_outcome got);
        t_fill_outcome exp;
        if (awaited.size() == 0) begin
            note_mismatch($sformatf("result with no fill outstanding: way %0d repl %0b evict %h total %0d",
                                    got.way, got.replaced, got.evicted, got.total));
        end else begin
            exp = awaited[0];
            awaited.delete(0);
            if (got.way !== exp.way || got.replaced !== exp.replaced ||
                got.evicted !== exp.evicted || got.total !== exp.total) begin
                note_mismatch($sformatf({"fill result mismatch: expected way %0d repl %0b ",
                                         "evict %h total %0d, got way %0d repl %0b evict %h total %0d"},
                                        exp.way, exp.replaced, exp.evicted, exp.total,
                                        got.way, got.replaced, got.evicted, got.total));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_fill_outcome predicted;
        t_fill_outcome observed;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++)
                for (int w = 0; w < WAYS; w++) line_valid[s][w] = 1'b0;
            stamp_now     = '0;
            evictions     = '0;
            policy_mirror = REPLACE_POLICY_RESET;
            awaited.delete();
        end else begin
            if (i_fill.valid && i_fill.ready) begin
                place_fill(i_fill.set_index, i_fill.fill_tag, predicted);
                awaited.push_back(predicted);
            end
            if (i_result.valid && i_result.ready) begin
                observed.way      = i_result.way_used;
                observed.replaced = i_result.replaced;
                observed.evicted  = i_result.evicted_tag;
                observed.total    = i_result.replacement_count;
                check_result(observed);
            end
            // Policy never changes a fill; mirror it only to check readback.
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_REPLACE_POLICY) begin
                if (pwrite) begin
                    policy_mirror = pwdata[0];
                end else if (prdata !== APB_DATA_W'(policy_mirror)) begin
                    note_mismatch($sformatf("replace_policy readback: expected %0d, got %h",
                                            policy_mirror, prdata));
                end
            end
        end
        o_pending    <= awaited.size();
        o_mismatches <= tally;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Drives fills into the tag-store fill engine with random idling on both
// channels, sweeps the replace_policy register between phases, and leaves
// all prediction and comparison to the checker.
module testbench;
    import safr_pkg::*;

    // Longest stretch with no transaction on either channel before giving up.
    // The slowest correct stretch comes from the long sink hold-off.
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [APB_ADDR_W-1:0] POLICY_ADDR = {REG_REPLACE_POLICY, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fails;
    int   pending;
    logic calm;          // no random idling on either side while set
    int   hold_asked;    // long sink hold-offs requested by the stimulus
    int   hold_served;   // ... and started by the sink

    safr_in_if  fill_in ();
    safr_out_if result_out ();

    set_assoc_fill_replace dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (fill_in),
        .o_out   (result_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fill_checker audit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill       (fill_in),
        .i_result     (result_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_mismatches (fails),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: random back-pressure, free flow while calm, and one long
    // hold-off per request so that the block backs up into its input.
    initial begin
        int stall_left;
        stall_left = 0;
        hold_served = 0;
        result_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_out.ready <= 1'b0;
                stall_left = 0;
            end else if (hold_asked != hold_served) begin
                hold_served++;
                stall_left = HOLD_CYCLES;
                result_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_out.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                result_out.ready <= 1'b0;
            end else begin
                result_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (fill_in.valid && fill_in.ready) ||
                (result_out.valid && result_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // One register transaction: setup cycle, then access until pready.
    // Drop psel afterwards and wait for the next clock edge so back-to-back calls never
    // assign the same signal twice in one step.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the policy and read it back; the checker compares the readback.
    task automatic set_policy(input logic value);
        apb_access(1'b1, POLICY_ADDR, APB_DATA_W'(value));
        apb_access(1'b0, POLICY_ADDR, '0);
    endtask

    // Offer one fill and hold it until the block takes it. Keep valid high on
    // return: the next call either drops it for a gap or reloads the payload.
    task automatic offer(input logic [SET_W-1:0] s, input logic [TAG_BITS-1:0] t);
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            fill_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fill_in.valid     <= 1'b1;
        fill_in.set_index <= s;
        fill_in.fill_tag  <= t;
        do @(posedge i_clk); while (!fill_in.ready);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline
    // settle before touching the register port.
    task automatic drain();
        fill_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random fills: a good share go to a few hot sets so evictions come early
    // and chain through every way; tags are mostly random with some extremes.
    task automatic random_fills(input int count);
        logic [SET_W-1:0]    s;
        logic [TAG_BITS-1:0] t;
        int                  r;
        for (int i = 0; i < count; i++) begin
            s = ($urandom_range(0, 99) < 40) ? SET_W'($urandom_range(0, 7))
                                              : SET_W'($urandom_range(0, SETS - 1));
            r = $urandom_range(0, 19);
            if (r == 0)      t = '0;
            else if (r == 1) t = '1;
            else             t = TAG_BITS'($urandom());
            offer(s, t);
        end
    endtask

    initial begin
        calm       = 1'b1;
        hold_asked = 0;
        i_rst_n           <= 1'b0;
        fill_in.valid     <= 1'b0;
        fill_in.set_index <= '0;
        fill_in.fill_tag  <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Policy should read back its reset value.
        apb_access(1'b0, POLICY_ADDR, '0);

        // Fill every way of the first and last set with extreme tags.
        offer(SET_W'(0), '0);
        offer(SET_W'(0), '1);
        offer(SET_W'(0), 26'h2AAAAAA);
        offer(SET_W'(0), 26'h1555555);
        offer(SET_W'(SETS - 1), '1);
        offer(SET_W'(SETS - 1), '0);
        offer(SET_W'(SETS - 1), 26'h1555555);
        offer(SET_W'(SETS - 1), 26'h2AAAAAA);
        // Evict around set 0 more than once: oldest stamp goes first each time.
        for (int k = 0; k < 5; k++) offer(SET_W'(0), TAG_BITS'(26'h0F0F0F0 + k));
        offer(SET_W'(SETS - 1), 26'h3FFFFFE);
        offer(SET_W'(42), 26'h0000001);
        offer(SET_W'(21), 26'h2000000);
        offer(SET_W'(42), 26'h3FFFFFF);
        drain();

        // First-in-first-out setting, with idling on both sides.
        set_policy(1'b0);
        calm = 1'b0;
        random_fills(400);
        drain();

        // Back to least recently stamped; start with a stretch of free flow.
        set_policy(1'b1);
        calm = 1'b1;
        random_fills(120);
        calm = 1'b0;
        random_fills(230);
        drain();

        // Hold the sink off while the source keeps offering back-to-back.
        set_policy(1'b0);
        calm = 1'b1;
        hold_asked++;
        random_fills(40);
        calm = 1'b0;
        random_fills(300);
        drain();

        set_policy(1'b1);
        repeat (20) @(posedge i_clk);

        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
